// File: hdl/masked_normalized_difference_core_defines.svh
// assertion macros used by the checker file
`ifndef MASKED_NORMALIZED_DIFFERENCE_CORE_DEFINES_SVH
`define MASKED_NORMALIZED_DIFFERENCE_CORE_DEFINES_SVH

// property checked out of reset, clocked on clk
`define MND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define MND_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/mnd_pkg.sv
// shared constants and types of the masked normalized difference core
package mnd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 15;
  localparam int CLASS_COUNT_DEF = 12;
  localparam int CLASS_CODE_BITS = 8;

  // classes 0,1,3,6,8,9,10,11 excluded after reset
  localparam logic [63:0] MASK_RESET_VAL = 64'd3915;

  // entries of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic no_data;
    logic neg;
    logic last;
  } cls_flags_t;

endpackage

// File: hdl/mnd_if.sv
// channel interfaces: pixel input, index result and mask write
interface mnd_in_if import mnd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [SAMPLE_BITS-1:0]     sample_a;
  logic [SAMPLE_BITS-1:0]     sample_b;
  logic [CLASS_CODE_BITS-1:0] scene_class;
  logic                       last_in;

  modport source (output valid, sample_a, sample_b, scene_class, last_in, input ready);
  modport sink   (input valid, sample_a, sample_b, scene_class, last_in, output ready);
endinterface

interface mnd_out_if import mnd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic signed [FRAC_BITS:0] index_value;
  logic                      no_data;
  logic                      last_out;

  modport source (output valid, index_value, no_data, last_out, input ready);
  modport sink   (input valid, index_value, no_data, last_out, output ready);
endinterface

interface mnd_cfg_if import mnd_pkg::*; #(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
);
  logic                   valid;
  logic                   ready;
  logic [CLASS_COUNT-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/mnd_front.sv
// front end: mask register, pixel classification, band sum and difference
module mnd_front import mnd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CLASS_COUNT = CLASS_COUNT_DEF,
  parameter int DATA_BITS   = $bits(cls_flags_t) + 2 * SAMPLE_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mnd_in_if.sink               in_ch,
  mnd_cfg_if.sink              cfg_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [DATA_BITS-1:0] q_data
);

  localparam logic [CLASS_COUNT-1:0] MaskReset = MASK_RESET_VAL[CLASS_COUNT-1:0];

  logic [CLASS_COUNT-1:0] excl_mask_r;
  logic [CLASS_COUNT-1:0] excl_shift;
  logic                   masked;
  logic [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS-1:0] mag;
  cls_flags_t             flags;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_mask_r <= MaskReset;
    end else if (cfg_ch.valid) begin
      excl_mask_r <= cfg_ch.data;
    end
  end

  // codes past the class list are always masked
  assign excl_shift = excl_mask_r >> in_ch.scene_class;
  assign masked = (in_ch.scene_class >= CLASS_CODE_BITS'(CLASS_COUNT)) | excl_shift[0];

  assign sum = {1'b0, in_ch.sample_a} + {1'b0, in_ch.sample_b};

  always_comb begin
    flags.neg     = in_ch.sample_b > in_ch.sample_a;
    flags.no_data = masked | (sum == '0);
    flags.last    = in_ch.last_in;
    mag = flags.neg ? (in_ch.sample_b - in_ch.sample_a) : (in_ch.sample_a - in_ch.sample_b);
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_data      = {flags, mag, sum};

endmodule

// File: hdl/mnd_queue.sv
// small word queue between the classifier and the divider pipeline
module mnd_queue import mnd_pkg::*; #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output logic [DATA_BITS-1:0] pop_data
);

  localparam int PtrBits = $clog2(QUEUE_DEPTH);
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0] mem_r [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_r;
  logic [PtrBits-1:0]   rd_ptr_r;
  logic [CntBits-1:0]   count_r;
  logic [CntBits-1:0]   count_nxt;

  assign full      = count_r == CntBits'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CntBits'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrBits'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrBits'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/mnd_back.sv
// back end: restoring divider, one quotient bit per stage, then sign and saturation
module mnd_back import mnd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int DATA_BITS   = $bits(cls_flags_t) + 2 * SAMPLE_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [DATA_BITS-1:0] q_data,
  output logic                 q_pop,
  mnd_out_if.source            out_ch
);

  localparam logic [FRAC_BITS:0] IndexTop = {1'b0, {FRAC_BITS{1'b1}}};

  cls_flags_t             q_flags;
  logic [SAMPLE_BITS-1:0] q_mag;
  logic [SAMPLE_BITS:0]   q_sum;
  logic [SAMPLE_BITS:0]   mag0;
  logic                   ge0;
  logic [SAMPLE_BITS:0]   rem0;

  logic [FRAC_BITS:0]     vld_r;
  logic [SAMPLE_BITS:0]   rem_r   [FRAC_BITS+1];
  logic [SAMPLE_BITS:0]   sum_r   [FRAC_BITS+1];
  logic [FRAC_BITS:0]     quo_r   [FRAC_BITS+1];
  cls_flags_t             flags_r [FRAC_BITS+1];

  logic [SAMPLE_BITS+1:0] trial   [FRAC_BITS+1];
  logic [FRAC_BITS:0]     step_ge;
  logic [SAMPLE_BITS:0]   rem_nxt [FRAC_BITS+1];

  logic                   en;
  logic                   out_valid_r;
  logic [FRAC_BITS:0]     index_r;
  logic [FRAC_BITS:0]     index_nxt;
  logic                   no_data_r;
  logic                   last_r;

  assign {q_flags, q_mag, q_sum} = q_data;

  // the whole pipeline moves whenever the output register can take a word
  assign en    = !out_valid_r || out_ch.ready;
  assign q_pop = en && q_valid;

  // top quotient bit: set only when the magnitude equals the sum
  assign mag0 = {1'b0, q_mag};
  assign ge0  = mag0 >= q_sum;
  assign rem0 = ge0 ? (mag0 - q_sum) : mag0;

  always_comb begin
    trial[0]   = '0;
    step_ge[0] = 1'b0;
    rem_nxt[0] = '0;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      trial[k]   = {rem_r[k-1], 1'b0};
      step_ge[k] = trial[k] >= {1'b0, sum_r[k-1]};
      rem_nxt[k] = step_ge[k] ? (SAMPLE_BITS+1)'(trial[k] - {1'b0, sum_r[k-1]})
                              : trial[k][SAMPLE_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FRAC_BITS-1:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]   <= rem0;
      sum_r[0]   <= q_sum;
      quo_r[0]   <= {{FRAC_BITS{1'b0}}, ge0};
      flags_r[0] <= q_flags;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        rem_r[k]   <= rem_nxt[k];
        sum_r[k]   <= sum_r[k-1];
        quo_r[k]   <= {quo_r[k-1][FRAC_BITS-1:0], step_ge[k]};
        flags_r[k] <= flags_r[k-1];
      end
    end
  end

  // +1 saturates, -1 is representable
  always_comb begin
    if (flags_r[FRAC_BITS].no_data) begin
      index_nxt = '0;
    end else if (flags_r[FRAC_BITS].neg) begin
      index_nxt = ~quo_r[FRAC_BITS] + {{FRAC_BITS{1'b0}}, 1'b1};
    end else if (quo_r[FRAC_BITS][FRAC_BITS]) begin
      index_nxt = IndexTop;
    end else begin
      index_nxt = quo_r[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index_r   <= index_nxt;
      no_data_r <= flags_r[FRAC_BITS].no_data;
      last_r    <= flags_r[FRAC_BITS].last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.index_value = index_r;
  assign out_ch.no_data     = no_data_r;
  assign out_ch.last_out    = last_r;

endmodule

// File: hdl/masked_normalized_difference_core.sv
// masked normalized difference core: (a-b)/(a+b) per pixel with class masking
//
// in_ch carries one pixel a word: two band samples, a scene class code and
// an end-of-image mark. out_ch returns one word per pixel in the same order:
// the index in signed Q1.FRAC_BITS rounded toward zero, a no-data flag and
// the end-of-image mark. cfg_ch writes the class exclusion mask and is
// always ready; the user must write it only while the core is idle, as the
// core does not enforce this. Throughput is one pixel per cycle while the
// receiver does not stall. A pixel passes the queue after the classifier,
// FRAC_BITS+1 divider stages that each settle one quotient bit with a
// compare and subtract, and the output register.
// When the receiver stalls, the divider pipeline holds and the four-word
// queue fills; in_ch.ready drops once the queue is full.
// Reset (synchronous, rst_n low) empties the queue and pipeline and loads
// the mask with its default, excluding classes 0,1,3,6,8,9,10 and 11.
module masked_normalized_difference_core import mnd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mnd_in_if.sink    in_ch,
  mnd_out_if.source out_ch,
  mnd_cfg_if.sink   cfg_ch
);

  localparam int DataBits = $bits(cls_flags_t) + 2 * SAMPLE_BITS + 1;

  logic                q_full;
  logic                q_push;
  logic [DataBits-1:0] q_push_data;
  logic                q_pop;
  logic                q_not_empty;
  logic [DataBits-1:0] q_pop_data;

  mnd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CLASS_COUNT (CLASS_COUNT),
    .DATA_BITS   (DataBits)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  mnd_queue #(
    .DATA_BITS (DataBits)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data)
  );

  mnd_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .DATA_BITS   (DataBits)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hdl/mnd_checker.sv
// port-level checks of the core and the bind that attaches them
`include "masked_normalized_difference_core_defines.svh"

module mnd_checker import mnd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [FRAC_BITS:0] out_index_value,
  input logic                      out_no_data,
  input logic                      out_last,
  input logic                      cfg_ready
);

  `MND_ASSERT(a_nodata_zero, out_valid && out_no_data |-> out_index_value == '0, "no-data word with nonzero index")
  `MND_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")
  `MND_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_index_value) && $stable(out_no_data) && $stable(out_last), "stalled result changed")
  `MND_ASSERT(a_cfg_ready, cfg_ready, "mask write port not ready")

endmodule

bind masked_normalized_difference_core mnd_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_mnd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_index_value (out_ch.index_value),
  .out_no_data     (out_ch.no_data),
  .out_last        (out_ch.last_out),
  .cfg_ready       (cfg_ch.ready)
);

// File: tb/sv/tb_masked_normalized_difference_core.sv
// testbench of the masked normalized difference core: directed pixel table, then random phases
`timescale 1ns / 1ps

module tb_masked_normalized_difference_core;
  import mnd_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int CC = CLASS_COUNT_DEF;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  localparam int PIPE_LATENCY = FB + 2;
  localparam int SETTLE_CYCLES = 4 * PIPE_LATENCY;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HEAVY_IDLE_PCT = 46;
  localparam int LIGHT_IDLE_PCT = 16;
  localparam int INDEX_TOP = (1 << FB) - 1;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int DIRECTED_ROWS = 20;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  // one pixel word, with an optional hand-written expectation
  typedef struct packed {
    logic [SB-1:0]              a;
    logic [SB-1:0]              b;
    logic [CLASS_CODE_BITS-1:0] cls;
    logic                       last;
    logic                       typed;
    logic signed [FB:0]         idx;
    logic                       nd;
  } pixel_row_t;

  typedef struct packed {
    logic signed [FB:0] idx;
    logic               nd;
    logic               last;
  } index_word_t;

  logic clk = 1'b0;
  logic rst_n;

  mnd_in_if  #(.SAMPLE_BITS(SB)) pix_ch ();
  mnd_out_if #(.FRAC_BITS(FB))   ndx_ch ();
  mnd_cfg_if #(.CLASS_COUNT(CC)) mask_ch ();

  masked_normalized_difference_core #(
    .SAMPLE_BITS(SB),
    .FRAC_BITS  (FB),
    .CLASS_COUNT(CC)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (pix_ch),
    .out_ch(ndx_ch),
    .cfg_ch(mask_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  index_word_t   index_queue[$];
  logic [CC-1:0] excl_mask_model;
  int            fail_count = 0;
  int            src_pct = 0;
  int            snk_pct = 0;
  int            hold_left = 0;

  pixel_row_t directed_rows [DIRECTED_ROWS] = '{
    // full positive ratio saturates, full negative ratio is exact
    '{16'd1000,  16'd0,     8'd2,   1'b0, 1'b1, 16'h7fff, 1'b0},
    '{16'd0,     16'd1000,  8'd4,   1'b0, 1'b1, 16'h8000, 1'b0},
    // zero band sum, equal bands, and full ratios at the sample extremes
    '{16'd0,     16'd0,     8'd2,   1'b0, 1'b1, 16'h0000, 1'b1},
    '{16'hffff,  16'hffff,  8'd5,   1'b0, 1'b1, 16'h0000, 1'b0},
    '{16'hffff,  16'd0,     8'd7,   1'b1, 1'b1, 16'h7fff, 1'b0},
    '{16'd0,     16'hffff,  8'd2,   1'b0, 1'b1, 16'h8000, 1'b0},
    '{16'd1,     16'd0,     8'd7,   1'b0, 1'b1, 16'h7fff, 1'b0},
    '{16'd0,     16'd1,     8'd5,   1'b0, 1'b1, 16'h8000, 1'b0},
    // excluded by the reset mask
    '{16'd1234,  16'd567,   8'd0,   1'b0, 1'b1, 16'h0000, 1'b1},
    '{16'hffff,  16'd0,     8'd11,  1'b1, 1'b1, 16'h0000, 1'b1},
    // class codes past the class count, then rows checked against ndi_predict
    '{16'd500,   16'd100,   8'd12,  1'b0, 1'b1, 16'h0000, 1'b1},
    '{16'd500,   16'd100,   8'd255, 1'b0, 1'b1, 16'h0000, 1'b1},
    '{16'd0,     16'd0,     8'd128, 1'b0, 1'b1, 16'h0000, 1'b1},
    '{16'hffff,  16'd1,     8'd4,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'd1,     16'hffff,  8'd5,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'd3,     16'd1,     8'd2,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'd1,     16'd3,     8'd2,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'haaaa,  16'h5555,  8'd7,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h5555,  16'haaaa,  8'd4,   1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'd40000, 16'd39999, 8'd2,   1'b0, 1'b0, 16'h0000, 1'b0}
  };

  function automatic index_word_t ndi_predict(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                              input logic [CLASS_CODE_BITS-1:0] cls,
                                              input logic last, input logic [CC-1:0] excl);
    index_word_t w;
    logic [SB:0] sum;
    logic [SB-1:0] mag;
    logic [SB+FB:0] quo;
    logic masked;
    sum = a + b;
    if (cls >= CC) masked = 1'b1;
    else masked = excl[cls];
    w.last = last;
    w.nd = 1'b0;
    w.idx = '0;
    if (masked || sum == 0) begin
      w.nd = 1'b1;
    end else begin
      mag = (b > a) ? b - a : a - b;
      // exact floor of |a-b| * 2^FB / (a+b)
      quo = ({{(FB+1){1'b0}}, mag} << FB) / {{FB{1'b0}}, sum};
      if (b > a) w.idx = -quo[FB:0];
      else if (quo > INDEX_TOP) w.idx = (FB+1)'(INDEX_TOP);
      else w.idx = quo[FB:0];
    end
    return w;
  endfunction

  task automatic send_pixel(input pixel_row_t r);
    int gap;
    index_word_t w;
    gap = 0;
    while (src_pct > 0 && $urandom_range(99) < src_pct) gap++;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.sample_a    <= r.a;
    pix_ch.sample_b    <= r.b;
    pix_ch.scene_class <= r.cls;
    pix_ch.last_in     <= r.last;
    do @(posedge clk); while (!pix_ch.ready);
    if (r.typed) begin
      w.idx = r.idx;
      w.nd = r.nd;
      w.last = r.last;
    end else begin
      w = ndi_predict(r.a, r.b, r.cls, r.last, excl_mask_model);
    end
    index_queue.push_back(w);
  endtask

  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    while (index_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_exclude_mask(input logic [CC-1:0] m);
    mask_ch.valid <= 1'b1;
    mask_ch.data  <= m;
    do @(posedge clk); while (!mask_ch.ready);
    mask_ch.valid <= 1'b0;
    excl_mask_model = m;
  endtask

  task automatic run_phase(input logic [CC-1:0] m, input idle_mode_t mode, input int count,
                           input int hold);
    pixel_row_t r;
    int kind;
    int pick;
    write_exclude_mask(m);
    case (mode)
      IDLE_NONE: begin src_pct = 0;              snk_pct = 0;              end
      IDLE_SRC:  begin src_pct = HEAVY_IDLE_PCT; snk_pct = 0;              end
      IDLE_SNK:  begin src_pct = 0;              snk_pct = HEAVY_IDLE_PCT; end
      default:   begin src_pct = LIGHT_IDLE_PCT; snk_pct = LIGHT_IDLE_PCT; end
    endcase
    hold_left = hold;
    repeat (count) begin
      r = '0;
      r.a = SB'($urandom_range((1 << SB) - 1));
      r.b = SB'($urandom_range((1 << SB) - 1));
      kind = $urandom_range(9);
      case (kind)
        0: r.a = '0;
        1: r.b = '0;
        2: begin r.a = '0; r.b = '0; end
        3: r.b = r.a;
        4: begin r.a = SB'($urandom_range(15)); r.b = SB'($urandom_range(15)); end
        default: ;
      endcase
      // mostly valid classes so that most words carry an in-range class code
      pick = $urandom_range(99);
      if (pick < 70) r.cls = CLASS_CODE_BITS'($urandom_range(CC - 1));
      else if (pick < 85) r.cls = CLASS_CODE_BITS'($urandom_range(CC + 3, CC));
      else r.cls = CLASS_CODE_BITS'($urandom_range((1 << CLASS_CODE_BITS) - 1));
      r.last = ($urandom_range(7) == 0);
      send_pixel(r);
    end
    drain_results();
  endtask

  // result side: check each accepted word, then pick next ready
  initial begin
    index_word_t w;
    ndx_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && ndx_ch.valid && ndx_ch.ready) begin
        if (index_queue.size() == 0) begin
          $error("result word with no pixel pending");
          fail_count++;
        end else begin
          w = index_queue.pop_front();
          if (ndx_ch.index_value !== w.idx) begin
            $error("index_value: expected %0d, got %0d", w.idx, ndx_ch.index_value);
            fail_count++;
          end
          if (ndx_ch.no_data !== w.nd) begin
            $error("no_data: expected %0b, got %0b", w.nd, ndx_ch.no_data);
            fail_count++;
          end
          if (ndx_ch.last_out !== w.last) begin
            $error("last_out: expected %0b, got %0b", w.last, ndx_ch.last_out);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        ndx_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        ndx_ch.ready <= ($urandom_range(99) >= snk_pct);
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    pix_ch.valid       <= 1'b0;
    pix_ch.sample_a    <= '0;
    pix_ch.sample_b    <= '0;
    pix_ch.scene_class <= '0;
    pix_ch.last_in     <= 1'b0;
    mask_ch.valid      <= 1'b0;
    mask_ch.data       <= '0;
    excl_mask_model = MASK_RESET_VAL[CC-1:0];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_pixel(directed_rows[i]);
    drain_results();

    run_phase({CC{1'b0}}, IDLE_NONE, 130, 0);
    run_phase({CC{1'b1}}, IDLE_SRC, 60, 0);
    run_phase(CC'($urandom_range((1 << CC) - 1)), IDLE_SNK, 180, 0);
    run_phase(MASK_RESET_VAL[CC-1:0], IDLE_BOTH, 180, 0);
    // long receiver hold-off while the sender keeps offering words
    run_phase({CC{1'b0}}, IDLE_NONE, 150, HOLD_OFF_CYCLES);
    run_phase(CC'($urandom_range((1 << CC) - 1)), IDLE_SRC, 180, 0);
    run_phase(CC'($urandom_range((1 << CC) - 1)), IDLE_SNK, 180, 0);
    run_phase(CC'($urandom_range((1 << CC) - 1)), IDLE_BOTH, 150, 0);
    run_phase(CC'($urandom_range((1 << CC) - 1)), IDLE_NONE, 80, 0);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/mnd_pkg.sv
hdl/mnd_if.sv
hdl/mnd_front.sv
hdl/mnd_queue.sv
hdl/mnd_back.sv
hdl/masked_normalized_difference_core.sv
hdl/mnd_checker.sv
tb/sv/tb_masked_normalized_difference_core.sv
